// ===== rtl/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, register codes and the CORDIC angle table for the odometry.
// ----------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

   localparam int CORDIC_STEPS_DEF = 20;
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 32;
   localparam int COUNT_W          = 32;
   localparam int POS_W            = 32;
   localparam int HEADING_W        = 25;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LEFT_STEP,
      REG_RIGHT_STEP,
      REG_INV_WHEELBASE,
      REG_GLITCH_LIMIT,
      REG_START_X,
      REG_START_Y,
      REG_START_HEADING
   } reg_index_type;

   typedef struct packed {
      logic [23:0]                  left_step;
      logic [23:0]                  right_step;
      logic [23:0]                  inv_wheelbase;
      logic [15:0]                  glitch_limit;
      logic signed [POS_W-1:0]      start_x;
      logic signed [POS_W-1:0]      start_y;
      logic signed [HEADING_W-1:0]  start_heading;
      logic                         pose_load;
   } cfg_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MUL_L,
      ST_MUL_R,
      ST_DIFF,
      ST_RAT_LO,
      ST_RAT_HI,
      ST_VLOAD,
      ST_VEC,
      ST_HEAD,
      ST_RLOAD,
      ST_ROT,
      ST_TRIG,
      ST_X_LO,
      ST_X_HI,
      ST_Y_LO,
      ST_Y_HI,
      ST_POS_Y,
      ST_FINISH
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_MUL_L,
      OP_MUL_R,
      OP_DIFF,
      OP_RAT_LO,
      OP_RAT_HI,
      OP_VLOAD,
      OP_VEC,
      OP_HEAD,
      OP_RLOAD,
      OP_ROT,
      OP_TRIG,
      OP_X_LO,
      OP_X_HI,
      OP_Y_LO,
      OP_Y_HI,
      OP_POS_Y
   } op_type;

   typedef struct packed {
      op_type op;
      logic   emit;
   } cmd_type;

   typedef struct packed {
      logic reject;
   } status_type;

   // atan(2^-i) in degrees, Q.24
   function automatic logic [31:0] ddo_atan_step(input logic [4:0] idx);
      logic [63:0] tail;
      begin
         tail = (64'd961263669 + (64'd1 << (idx - 5'd1))) >> idx;
         case (idx)
            5'd0:    ddo_atan_step = 32'd754974720;
            5'd1:    ddo_atan_step = 32'd445687602;
            5'd2:    ddo_atan_step = 32'd235489088;
            5'd3:    ddo_atan_step = 32'd119537938;
            5'd4:    ddo_atan_step = 32'd60000934;
            5'd5:    ddo_atan_step = 32'd30029717;
            5'd6:    ddo_atan_step = 32'd15018523;
            5'd7:    ddo_atan_step = 32'd7509720;
            5'd8:    ddo_atan_step = 32'd3754917;
            5'd9:    ddo_atan_step = 32'd1877466;
            5'd10:   ddo_atan_step = 32'd938734;
            5'd11:   ddo_atan_step = 32'd469367;
            5'd12:   ddo_atan_step = 32'd234684;
            5'd13:   ddo_atan_step = 32'd117342;
            5'd14:   ddo_atan_step = 32'd58671;
            5'd15:   ddo_atan_step = 32'd29335;
            default: ddo_atan_step = tail[31:0];
         endcase
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ddo_csr.sv =====
// ----------------------------------------------------------------------------
// ddo_csr
// Configuration registers and the start-pose reload pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wen,
   input  wire logic [ddo_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [ddo_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output ddo_pkg::cfg_type                       cfg
);
   import ddo_pkg::*;

   logic [23:0]                 left_step_ff, left_step_in;
   logic [23:0]                 right_step_ff, right_step_in;
   logic [23:0]                 inv_wb_ff, inv_wb_in;
   logic [15:0]                 glitch_ff, glitch_in;
   logic [POS_W-1:0]            start_x_ff, start_x_in;
   logic [POS_W-1:0]            start_y_ff, start_y_in;
   logic [HEADING_W-1:0]        start_head_ff, start_head_in;
   logic                        load_ff, load_in;

   always_comb begin
      left_step_in  = left_step_ff;
      right_step_in = right_step_ff;
      inv_wb_in     = inv_wb_ff;
      glitch_in     = glitch_ff;
      start_x_in    = start_x_ff;
      start_y_in    = start_y_ff;
      start_head_in = start_head_ff;
      load_in       = 1'b0;
      if (csr_wen) begin
         unique case (reg_index_type'(csr_index))
            REG_LEFT_STEP:     left_step_in  = csr_wdata[23:0];
            REG_RIGHT_STEP:    right_step_in = csr_wdata[23:0];
            REG_INV_WHEELBASE: inv_wb_in     = csr_wdata[23:0];
            REG_GLITCH_LIMIT:  glitch_in     = csr_wdata[15:0];
            REG_START_X: begin
               start_x_in = csr_wdata;
               load_in    = 1'b1;
            end
            REG_START_Y: begin
               start_y_in = csr_wdata;
               load_in    = 1'b1;
            end
            REG_START_HEADING: begin
               start_head_in = csr_wdata[HEADING_W-1:0];
               load_in       = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_step_ff  <= '0;
         right_step_ff <= '0;
         inv_wb_ff     <= 24'd65793;
         glitch_ff     <= 16'd300;
         start_x_ff    <= '0;
         start_y_ff    <= '0;
         start_head_ff <= '0;
         load_ff       <= 1'b0;
      end else begin
         left_step_ff  <= left_step_in;
         right_step_ff <= right_step_in;
         inv_wb_ff     <= inv_wb_in;
         glitch_ff     <= glitch_in;
         start_x_ff    <= start_x_in;
         start_y_ff    <= start_y_in;
         start_head_ff <= start_head_in;
         load_ff       <= load_in;
      end
   end

   always_comb begin
      cfg.left_step     = left_step_ff;
      cfg.right_step    = right_step_ff;
      cfg.inv_wheelbase = inv_wb_ff;
      cfg.glitch_limit  = glitch_ff;
      cfg.start_x       = $signed(start_x_ff);
      cfg.start_y       = $signed(start_y_ff);
      cfg.start_heading = $signed(start_head_ff);
      cfg.pose_load     = load_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/ddo_ctrl.sv =====
// ----------------------------------------------------------------------------
// ddo_ctrl
// Sequencer for one sample: multiplies, two CORDIC passes, pose update.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_ctrl #(
   parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic                             out_free,
   input  ddo_pkg::status_type                   status,
   output ddo_pkg::cmd_type                      cmd,
   output logic [$clog2(CORDIC_STEPS)-1:0]       iter
);
   import ddo_pkg::*;

   localparam int ITER_W = $clog2(CORDIC_STEPS);

   state_type           state_ff, state_in;
   logic [ITER_W-1:0]   cnt_ff, cnt_in;
   logic                last_iter;

   assign last_iter = (cnt_ff == ITER_W'(CORDIC_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_MUL_L;
         ST_MUL_L:  state_in = status.reject ? ST_FINISH : ST_MUL_R;
         ST_MUL_R:  state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_RAT_LO;
         ST_RAT_LO: state_in = ST_RAT_HI;
         ST_RAT_HI: state_in = ST_VLOAD;
         ST_VLOAD:  state_in = ST_VEC;
         ST_VEC:    if (last_iter) state_in = ST_HEAD;
         ST_HEAD:   state_in = ST_RLOAD;
         ST_RLOAD:  state_in = ST_ROT;
         ST_ROT:    if (last_iter) state_in = ST_TRIG;
         ST_TRIG:   state_in = ST_X_LO;
         ST_X_LO:   state_in = ST_X_HI;
         ST_X_HI:   state_in = ST_Y_LO;
         ST_Y_LO:   state_in = ST_Y_HI;
         ST_Y_HI:   state_in = ST_POS_Y;
         ST_POS_Y:  state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op     = OP_NONE;
      cmd.emit   = 1'b0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = OP_CAPTURE;
         end
         ST_MUL_L:  cmd.op = OP_MUL_L;
         ST_MUL_R:  cmd.op = OP_MUL_R;
         ST_DIFF:   cmd.op = OP_DIFF;
         ST_RAT_LO: cmd.op = OP_RAT_LO;
         ST_RAT_HI: cmd.op = OP_RAT_HI;
         ST_VLOAD:  cmd.op = OP_VLOAD;
         ST_VEC:    cmd.op = OP_VEC;
         ST_HEAD:   cmd.op = OP_HEAD;
         ST_RLOAD:  cmd.op = OP_RLOAD;
         ST_ROT:    cmd.op = OP_ROT;
         ST_TRIG:   cmd.op = OP_TRIG;
         ST_X_LO:   cmd.op = OP_X_LO;
         ST_X_HI:   cmd.op = OP_X_HI;
         ST_Y_LO:   cmd.op = OP_Y_LO;
         ST_Y_HI:   cmd.op = OP_Y_HI;
         ST_POS_Y:  cmd.op = OP_POS_Y;
         ST_FINISH: cmd.emit = out_free;
         default:   cmd.op = OP_NONE;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (state_ff == ST_VLOAD || state_ff == ST_RLOAD) begin
         cnt_in = '0;
      end else if (state_ff == ST_VEC || state_ff == ST_ROT) begin
         cnt_in = cnt_ff + ITER_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign iter = cnt_ff;

endmodule

`default_nettype wire

// ===== rtl/ddo_dp.sv =====
// ----------------------------------------------------------------------------
// ddo_dp
// Odometry datapath: deltas, shared multiplier, shared CORDIC, pose.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_dp #(
   parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  ddo_pkg::cfg_type                            cfg,
   input  ddo_pkg::cmd_type                            cmd,
   input  wire logic [$clog2(CORDIC_STEPS)-1:0]        iter,
   input  wire logic [ddo_pkg::COUNT_W-1:0]            left_count,
   input  wire logic [ddo_pkg::COUNT_W-1:0]            right_count,
   output ddo_pkg::status_type                         status,
   output logic signed [ddo_pkg::POS_W-1:0]            pos_x,
   output logic signed [ddo_pkg::POS_W-1:0]            pos_y,
   output logic signed [ddo_pkg::HEADING_W-1:0]        heading_out
);
   import ddo_pkg::*;

   localparam logic signed [26:0] HALF_TURN   = 27'sd11796480;
   localparam logic signed [26:0] FULL_TURN   = 27'sd23592960;
   localparam logic signed [33:0] QUARTER_Q24 = 34'sd1509949440;
   localparam logic signed [33:0] HALF_Q24    = 34'sd3019898880;
   localparam logic signed [57:0] GAIN_INV    = 58'sd652032874;
   localparam logic signed [57:0] VEC_X0      = 58'sd1073741824;

   function automatic logic signed [HEADING_W-1:0] wrap_heading(
      input logic signed [26:0] h);
      logic signed [26:0] r;
      begin
         if (h >= HALF_TURN) r = h - FULL_TURN;
         else if (h < -HALF_TURN) r = h + FULL_TURN;
         else r = h;
         wrap_heading = r[HEADING_W-1:0];
      end
   endfunction

   logic [COUNT_W-1:0]          prev_left_ff, prev_left_in;
   logic [COUNT_W-1:0]          prev_right_ff, prev_right_in;
   logic signed [16:0]          dl_ff, dl_in, dr_ff, dr_in;
   logic                        reject_ff, reject_in;
   logic signed [40:0]          distl_ff, distl_in, distr_ff, distr_in;
   logic [41:0]                 dmag_ff, dmag_in;
   logic                        dneg_ff, dneg_in;
   logic signed [32:0]          travel_ff, travel_in;
   logic signed [65:0]          acc_ff, acc_in;
   logic                        rzero_ff, rzero_in;
   logic                        fold_ff, fold_in;
   logic signed [57:0]          cx_ff, cx_in, cy_ff, cy_in;
   logic signed [33:0]          cz_ff, cz_in;
   logic signed [32:0]          c_ff, c_in, s_ff, s_in;
   logic signed [POS_W-1:0]     pose_x_ff, pose_x_in, pose_y_ff, pose_y_in;
   logic signed [HEADING_W-1:0] head_ff, head_in;

   logic [COUNT_W-1:0]          dl_full, dr_full, dl_abs, dr_abs;
   logic [COUNT_W:0]            mag;
   logic signed [21:0]          mul_a;
   logic signed [32:0]          mul_b;
   logic signed [54:0]          prod;
   logic signed [65:0]          prod_ext;
   logic signed [41:0]          diff;
   logic signed [42:0]          tsum;
   logic [41:0]                 rmag;
   logic signed [41:0]          ratio;
   logic signed [33:0]          zr;
   logic signed [25:0]          atan_q16;
   logic signed [33:0]          hz;
   logic signed [57:0]          xs, ys;
   logic signed [33:0]          ang;
   logic                        sigma;
   logic signed [65:0]          rounded;

   assign dl_full = left_count - prev_left_ff;
   assign dr_full = right_count - prev_right_ff;
   assign dl_abs  = dl_full[COUNT_W-1] ? (~dl_full + 32'd1) : dl_full;
   assign dr_abs  = dr_full[COUNT_W-1] ? (~dr_full + 32'd1) : dr_full;
   assign mag     = {1'b0, dl_abs} + {1'b0, dr_abs};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MUL_L: begin
            mul_a = 22'(dl_ff);
            mul_b = $signed({9'b0, cfg.left_step});
         end
         OP_MUL_R: begin
            mul_a = 22'(dr_ff);
            mul_b = $signed({9'b0, cfg.right_step});
         end
         OP_RAT_LO: begin
            mul_a = $signed({1'b0, dmag_ff[20:0]});
            mul_b = $signed({9'b0, cfg.inv_wheelbase});
         end
         OP_RAT_HI: begin
            mul_a = $signed({1'b0, dmag_ff[41:21]});
            mul_b = $signed({9'b0, cfg.inv_wheelbase});
         end
         OP_X_LO: begin
            mul_a = $signed({6'b0, travel_ff[15:0]});
            mul_b = c_ff;
         end
         OP_X_HI: begin
            mul_a = 22'($signed(travel_ff[32:16]));
            mul_b = c_ff;
         end
         OP_Y_LO: begin
            mul_a = $signed({6'b0, travel_ff[15:0]});
            mul_b = s_ff;
         end
         OP_Y_HI: begin
            mul_a = 22'($signed(travel_ff[32:16]));
            mul_b = s_ff;
         end
         default: ;
      endcase
   end

   assign prod     = mul_a * mul_b;
   assign prod_ext = 66'(prod);

   assign diff     = 42'(distl_ff) - 42'(distr_ff);
   assign tsum     = 43'(distl_ff) + 43'(distr_ff) + 43'sd256;
   assign rmag     = acc_ff[65:24];
   assign ratio    = dneg_ff ? -$signed(rmag) : $signed(rmag);
   assign zr       = cz_ff + 34'sd128;
   assign atan_q16 = rzero_ff ? 26'sd0 : zr[33:8];
   assign hz       = 34'(head_ff) <<< 8;
   assign xs       = cx_ff >>> iter;
   assign ys       = cy_ff >>> iter;
   assign ang      = $signed({2'b0, ddo_atan_step(5'(iter))});
   assign sigma    = (cmd.op == OP_VEC) ? cy_ff[57] : ~cz_ff[33];
   assign rounded  = acc_ff + 66'sd536870912;

   always_comb begin
      prev_left_in  = prev_left_ff;
      prev_right_in = prev_right_ff;
      dl_in         = dl_ff;
      dr_in         = dr_ff;
      reject_in     = reject_ff;
      distl_in      = distl_ff;
      distr_in      = distr_ff;
      dmag_in       = dmag_ff;
      dneg_in       = dneg_ff;
      travel_in     = travel_ff;
      acc_in        = acc_ff;
      rzero_in      = rzero_ff;
      fold_in       = fold_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      cz_in         = cz_ff;
      c_in          = c_ff;
      s_in          = s_ff;
      pose_x_in     = pose_x_ff;
      pose_y_in     = pose_y_ff;
      head_in       = head_ff;
      case (cmd.op)
         OP_CAPTURE: begin
            prev_left_in  = left_count;
            prev_right_in = right_count;
            dl_in         = $signed(dl_full[16:0]);
            dr_in         = $signed(dr_full[16:0]);
            reject_in     = (mag >= {17'b0, cfg.glitch_limit});
         end
         OP_MUL_L: distl_in = prod[40:0];
         OP_MUL_R: distr_in = prod[40:0];
         OP_DIFF: begin
            dneg_in   = diff[41];
            dmag_in   = diff[41] ? 42'(-diff) : 42'(diff);
            travel_in = tsum[41:9];
         end
         OP_RAT_LO: acc_in = prod_ext;
         OP_RAT_HI: acc_in = acc_ff + (prod_ext <<< 21);
         OP_VLOAD: begin
            rzero_in = (rmag == 42'd0);
            cx_in    = VEC_X0;
            cy_in    = 58'(ratio) <<< 14;
            cz_in    = '0;
         end
         OP_VEC, OP_ROT: begin
            if (sigma) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - ang;
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + ang;
            end
         end
         OP_HEAD: head_in = wrap_heading(27'(head_ff) + 27'(atan_q16));
         OP_RLOAD: begin
            cx_in = GAIN_INV;
            cy_in = '0;
            if (hz > QUARTER_Q24) begin
               cz_in   = hz - HALF_Q24;
               fold_in = 1'b1;
            end else if (hz < -QUARTER_Q24) begin
               cz_in   = hz + HALF_Q24;
               fold_in = 1'b1;
            end else begin
               cz_in   = hz;
               fold_in = 1'b0;
            end
         end
         OP_TRIG: begin
            c_in = 33'(fold_ff ? -cx_ff : cx_ff);
            s_in = 33'(fold_ff ? -cy_ff : cy_ff);
         end
         OP_X_LO: acc_in = prod_ext;
         OP_X_HI: acc_in = acc_ff + (prod_ext <<< 16);
         OP_Y_LO: begin
            pose_x_in = pose_x_ff + rounded[61:30];
            acc_in    = prod_ext;
         end
         OP_Y_HI: acc_in = acc_ff + (prod_ext <<< 16);
         OP_POS_Y: pose_y_in = pose_y_ff + rounded[61:30];
         default: ;
      endcase
      if (cfg.pose_load) begin
         pose_x_in = cfg.start_x;
         pose_y_in = cfg.start_y;
         head_in   = wrap_heading(27'(cfg.start_heading));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_left_ff  <= '0;
         prev_right_ff <= '0;
         reject_ff     <= 1'b0;
         pose_x_ff     <= '0;
         pose_y_ff     <= '0;
         head_ff       <= '0;
      end else begin
         prev_left_ff  <= prev_left_in;
         prev_right_ff <= prev_right_in;
         reject_ff     <= reject_in;
         pose_x_ff     <= pose_x_in;
         pose_y_ff     <= pose_y_in;
         head_ff       <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      dl_ff     <= dl_in;
      dr_ff     <= dr_in;
      distl_ff  <= distl_in;
      distr_ff  <= distr_in;
      dmag_ff   <= dmag_in;
      dneg_ff   <= dneg_in;
      travel_ff <= travel_in;
      acc_ff    <= acc_in;
      rzero_ff  <= rzero_in;
      fold_ff   <= fold_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      cz_ff     <= cz_in;
      c_ff      <= c_in;
      s_ff      <= s_in;
   end

   assign status.reject = reject_ff;
   assign pos_x         = pose_x_ff;
   assign pos_y         = pose_y_ff;
   assign heading_out   = head_ff;

endmodule

`default_nettype wire

// ===== rtl/differential_drive_odometry_top.sv =====
// ----------------------------------------------------------------------------
// differential_drive_odometry_top
// Dead-reckoning pose tracker for a two-wheel drive, fed by encoder counts.
// ----------------------------------------------------------------------------
// Usage:
//  req channel carries one beat per sample with the absolute left and right
//  encoder counts. rsp channel returns one beat per sample with the new pose
//  (x, y in Q.8 mm, heading in Q.16 degrees) and a reject flag in tuser.
//  csr port writes the step lengths, wheelbase reciprocal, glitch limit and
//  the start pose; any start-pose write reloads the whole pose.
//  An accepted sample steps through the multiplies, the arctangent pass and
//  the sine/cosine pass, which share one CORDIC stage and one multiplier,
//  before its result beat is loaded; a rejected sample skips the rest of
//  the sequence and has its result loaded. One sample is worked on at a
//  time; the next one is taken in the cycle after the previous result is
//  loaded into the output register. If the receiver stalls, the result
//  holds and the finished sample waits at the end of its sequence.
//  Reset clears the counts and pose and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_odometry_top #(
   parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [63:0]                       req_tdata,  // left_count, right_count
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [95:0]                            rsp_tdata,  // pos_x, pos_y, heading_out
   output logic                                   rsp_tuser,  // rejected
   input  wire logic                              csr_wen,
   input  wire logic [ddo_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [ddo_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ddo_pkg::*;

   cfg_type                         cfg;
   cmd_type                         cmd;
   status_type                      status;
   logic [$clog2(CORDIC_STEPS)-1:0] iter;
   logic                            out_free;
   logic signed [POS_W-1:0]         pos_x, pos_y;
   logic signed [HEADING_W-1:0]     heading;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [95:0]                     rsp_data_ff, rsp_data_in;
   logic                            rsp_user_ff, rsp_user_in;

   ddo_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ddo_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .out_free   (out_free),
      .status     (status),
      .cmd        (cmd),
      .iter       (iter)
   );

   ddo_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .iter        (iter),
      .left_count  (req_tdata[31:0]),
      .right_count (req_tdata[63:32]),
      .status      (status),
      .pos_x       (pos_x),
      .pos_y       (pos_y),
      .heading_out (heading)
   );

   assign out_free = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'b0, heading, pos_y, pos_x};
         rsp_user_in  = status.reject;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Encoder samples go in on the req stream and pose results come back on the
// rsp stream. An in-bench fixed-point odometry predictor works out each pose,
// and every rsp beat is checked field by field against the oldest prediction.
// Directed samples cover the field extremes, count wrap, glitch rejects and
// pose reloads. Random phases then apply random configurations and mostly
// well-formed motion, with random idling on both sides except in the last phase.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ddo_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] REG_SPARE = 3'd7;
   localparam longint HALF_TURN  = 64'sd11796480;
   localparam longint FULL_TURN  = 64'sd23592960;
   localparam longint QUARTER_24 = 64'sd1509949440;
   localparam longint HALF_24    = 64'sd3019898880;
   localparam longint GAIN_INV   = 64'sd652032874;
   localparam int     ITERS      = 20;
   localparam longint ARC_TAB [16] = '{754974720, 445687602, 235489088, 119537938,
      60000934, 30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335};

   typedef struct {
      logic [31:0] left;
      logic [31:0] right;
   } sample_t;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [24:0] heading;
      logic        rejected;
   } pose_t;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_wen    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   differential_drive_odometry_top u_top (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_wen, .csr_index, .csr_wdata
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // predictor state and configuration copies
   logic [23:0] step_l, step_r, inv_base;
   logic [15:0] glitch_lim;
   logic [31:0] start_x_reg, start_y_reg;
   logic [24:0] start_h_reg;
   logic [31:0] last_left, last_right;
   longint      track_x, track_y, track_h;

   sample_t pending_samples[$];
   pose_t   expected_poses[$];
   logic [31:0] gen_left, gen_right;
   sample_t     beat;
   bit  beat_taken;
   bit  quiet;
   int  send_gap, recv_gap, hold_left;
   int  fail_count;

   function automatic longint arc_step(input int i);
      if (i < 16) return ARC_TAB[i];
      return longint'((64'd961263669 + (64'd1 << (i - 1))) >> i);
   endfunction

   function automatic longint wrap_turn(input longint h);
      longint r;
      r = (h + HALF_TURN) % FULL_TURN;
      if (r < 0) r += FULL_TURN;
      return r - HALF_TURN;
   endfunction

   function automatic longint scale_ratio(input longint d, input logic [23:0] inv);
      logic [63:0] m;
      logic [89:0] p;
      longint      r;
      m = (d < 0) ? 64'(-d) : 64'(d);
      p = {26'b0, m} * {66'b0, inv};
      r = longint'(p[87:24]);
      return (d < 0) ? -r : r;
   endfunction

   function automatic longint atan_deg(input longint ratio);
      longint x, y, z, xs, ys;
      x = 64'sd1 << 30;
      y = ratio * 16384;
      z = 0;
      if (ratio == 0) return 0;
      for (int i = 0; i < ITERS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += arc_step(i);
         end else begin
            x -= ys; y += xs; z -= arc_step(i);
         end
      end
      return (z + 128) >>> 8;
   endfunction

   task automatic sin_cos(input longint h, output longint c, output longint s);
      longint z, x, y, xs, ys;
      bit     flip;
      z = h * 256;
      x = GAIN_INV;
      y = 0;
      flip = 0;
      if (z > QUARTER_24) begin
         z -= HALF_24; flip = 1;
      end else if (z < -QUARTER_24) begin
         z += HALF_24; flip = 1;
      end
      for (int i = 0; i < ITERS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= arc_step(i);
         end else begin
            x += ys; y -= xs; z += arc_step(i);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic void reload_pose();
      track_x = longint'($signed(start_x_reg));
      track_y = longint'($signed(start_y_reg));
      track_h = wrap_turn(longint'($signed(start_h_reg)));
   endfunction

   task automatic advance_pose(input sample_t smp, output pose_t p);
      logic signed [31:0] d32l, d32r;
      longint dl, dr, dist_l, dist_r, travel, c, s;
      bit     rej;
      d32l = $signed(smp.left - last_left);
      d32r = $signed(smp.right - last_right);
      dl = d32l;
      dr = d32r;
      rej = ((dl < 0 ? -dl : dl) + (dr < 0 ? -dr : dr)) >= longint'(glitch_lim);
      last_left = smp.left;
      last_right = smp.right;
      if (!rej) begin
         dist_l = dl * longint'(step_l);
         dist_r = dr * longint'(step_r);
         travel = (dist_l + dist_r + 256) >>> 9;
         track_h = wrap_turn(track_h + atan_deg(scale_ratio(dist_l - dist_r, inv_base)));
         sin_cos(track_h, c, s);
         track_x = longint'($signed(32'(track_x + ((travel * c + (64'sd1 << 29)) >>> 30))));
         track_y = longint'($signed(32'(track_y + ((travel * s + (64'sd1 << 29)) >>> 30))));
      end
      p.x = 32'(track_x);
      p.y = 32'(track_y);
      p.heading = 25'(track_h);
      p.rejected = rej;
   endtask

   // req driver
   always @(negedge clock) begin
      if (!req_tvalid || beat_taken) begin
         if (send_gap > 0) begin
            req_tvalid <= 1'b0;
            send_gap--;
         end else if (!reset && pending_samples.size() > 0) begin
            beat = pending_samples.pop_front();
            req_tdata <= {beat.right, beat.left};
            req_tvalid <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 8);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // rsp ready driver
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (recv_gap > 0) begin
         rsp_tready <= 1'b0;
         recv_gap--;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet && $urandom_range(0, 6) == 0) recv_gap = $urandom_range(1, 8);
      end
   end

   // predict on req beats, check rsp beats
   always @(posedge clock) begin
      sample_t smp;
      pose_t   want;
      beat_taken = req_tvalid && req_tready;
      if (beat_taken) begin
         smp.left = req_tdata[31:0];
         smp.right = req_tdata[63:32];
         advance_pose(smp, want);
         expected_poses.push_back(want);
      end
      if (rsp_tvalid && rsp_tready) begin
         if (expected_poses.size() == 0) begin
            $error("unexpected rsp beat");
            fail_count++;
         end else begin
            want = expected_poses.pop_front();
            if (rsp_tdata[31:0] !== want.x) begin
               $error("pos_x: expected %0d, got %0d", $signed(want.x), $signed(rsp_tdata[31:0]));
               fail_count++;
            end
            if (rsp_tdata[63:32] !== want.y) begin
               $error("pos_y: expected %0d, got %0d", $signed(want.y),
                      $signed(rsp_tdata[63:32]));
               fail_count++;
            end
            if (rsp_tdata[88:64] !== want.heading) begin
               $error("heading_out: expected %0d, got %0d", $signed(want.heading),
                      $signed(rsp_tdata[88:64]));
               fail_count++;
            end
            if (rsp_tdata[95:89] !== 7'd0) begin
               $error("tdata pad: expected 0, got %0h", rsp_tdata[95:89]);
               fail_count++;
            end
            if (rsp_tuser !== want.rejected) begin
               $error("rejected: expected %0b, got %0b", want.rejected, rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] v);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         REG_LEFT_STEP:     step_l = v[23:0];
         REG_RIGHT_STEP:    step_r = v[23:0];
         REG_INV_WHEELBASE: inv_base = v[23:0];
         REG_GLITCH_LIMIT:  glitch_lim = v[15:0];
         REG_START_X: begin
            start_x_reg = v;
            reload_pose();
         end
         REG_START_Y: begin
            start_y_reg = v;
            reload_pose();
         end
         REG_START_HEADING: begin
            start_h_reg = v[24:0];
            reload_pose();
         end
         default: ;
      endcase
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic configure(input logic [23:0] l, r, inv, input logic [15:0] lim,
                            input logic [31:0] sx, sy, sh);
      csr_write(REG_LEFT_STEP, {8'd0, l});
      csr_write(REG_RIGHT_STEP, {8'd0, r});
      csr_write(REG_INV_WHEELBASE, {8'd0, inv});
      csr_write(REG_GLITCH_LIMIT, {16'd0, lim});
      csr_write(REG_START_X, sx);
      csr_write(REG_START_Y, sy);
      csr_write(REG_START_HEADING, sh);
   endtask

   task automatic push_counts(input logic [31:0] l, r);
      sample_t s;
      s.left = l;
      s.right = r;
      pending_samples.push_back(s);
      gen_left = l;
      gen_right = r;
   endtask

   task automatic push_step(input int dl, dr);
      push_counts(gen_left + 32'(dl), gen_right + 32'(dr));
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_samples.size() != 0 || req_tvalid || expected_poses.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      #20_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      int span, lim;
      step_l = 0; step_r = 0; inv_base = 24'd65793; glitch_lim = 16'd300;
      start_x_reg = 0; start_y_reg = 0; start_h_reg = 0;
      last_left = 0; last_right = 0;
      gen_left = 0; gen_right = 0;
      reload_pose();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      configure(24'h018000, 24'h018000, 24'd55924, 16'd300, 0, 0, 0);
      push_counts(0, 0);
      push_counts(10, 10);
      push_counts(30, 15);
      push_counts(25, 40);
      push_counts(-50, -60);
      push_counts(-50, -60);
      push_counts(1000, 0);
      push_counts(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      push_counts(32'h8000_0000, 32'h8000_0005);
      push_counts(32'h8000_0000, 32'h7FFF_FFFF);
      push_counts(32'hFFFF_FFFF, 32'h0000_0000);
      drain();

      configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h00FF_FFFF);
      push_step(32767, 32767);
      push_step(-32767, 32767);
      push_step(40000, -25535);
      push_step(0, 0);
      push_step(-65534, 0);
      drain();

      configure(0, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'(-11796480));
      push_step(0, 0);
      push_step(1, -1);
      drain();
      csr_write(REG_GLITCH_LIMIT, 32'd1);
      csr_write(REG_START_HEADING, 32'd11796479);
      csr_write(REG_SPARE, 32'hFFFF_FFFF);
      push_step(0, 0);
      drain();
      csr_write(REG_LEFT_STEP, 32'h00_0200);
      csr_write(REG_RIGHT_STEP, 32'h00_0300);
      drain();
      csr_write(REG_GLITCH_LIMIT, 32'd20);
      push_step(3, -9);
      push_step(-7, 2);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case ($urandom_range(0, 5))
            0:       lim = 0;
            1:       lim = 1;
            2:       lim = $urandom_range(2, 64);
            default: lim = $urandom_range(65, 65535);
         endcase
         configure(24'($urandom), 24'($urandom), 24'($urandom), 16'(lim),
                   $urandom, $urandom, $urandom);
         quiet = (ph == 5);
         span = lim >> 1;
         for (int k = 0; k < 110; k++) begin
            if ($urandom_range(0, 99) < 15)
               push_counts($urandom, $urandom);
            else
               push_step(int'($urandom_range(0, 2 * span)) - span,
                         int'($urandom_range(0, 2 * span)) - span);
         end
         if (ph == 2) hold_left = 600;
         drain();
      end

      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end
endmodule
